// ----- rtl/chp_pkg.sv -----
// Shared types and constants for the caldera height pixel pipeline.
// Used by chp_sqrt, chp_exp and caldera_height_pixel; depends on nothing.
package chp_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_CENTER_X          = 4'd0,
    REG_CENTER_Y          = 4'd1,
    REG_RIM_RADIUS        = 4'd2,
    REG_INNER_WIDTH       = 4'd3,
    REG_OUTER_WIDTH       = 4'd4,
    REG_BOTTOM_HEIGHT     = 4'd5,
    REG_RADIAL_NOISE_GAIN = 4'd6,
    REG_HEIGHT_NOISE_GAIN = 4'd7
  } reg_idx_t;

  // Q.12 value of one
  localparam logic signed [17:0] ONE_Q12 = 18'sd4096;

  // log2(e) and ln(2) in Q.30
  localparam logic [30:0] L2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // floor((2^32 - 1) / n) for the Horner divisions by n = 1..12
  localparam logic [31:0] RECIP [1:12] = '{
    32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
    32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
    32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941
  };

  // Sideband carried alongside the square root
  typedef struct packed {
    logic signed [17:0] nr;   // radial noise offset
    logic signed [17:0] m;    // height noise multiplier, Q.12
  } sq_side_t;

  // Sideband carried alongside the exponential
  typedef struct packed {
    logic               in_bowl;
    logic               deep;   // bowl term applies (inside, r^2 below 64 si^2)
    logic [12:0]        zo;     // falloff height, Q.12
    logic signed [17:0] m;
  } ex_side_t;

endpackage

// ----- rtl/chp_sqrt.sv -----
// Pipelined integer square root, one result bit per stage (17 stages).
// Depends on chp_pkg for the sideband type.
module chp_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [33:0]        radicand,
  input  chp_pkg::sq_side_t  side_in,
  output logic               out_valid,
  output logic [16:0]        root,
  output chp_pkg::sq_side_t  side_out
);

  logic              vld [1:17];
  logic [33:0]       rem [1:17];
  logic [16:0]       rt  [1:17];
  chp_pkg::sq_side_t sd  [1:17];

  for (genvar s = 0; s < 17; s++) begin : g_stage
    localparam int I = 16 - s;
    logic              cur_vld;
    logic [33:0]       cur_rem;
    logic [16:0]       cur_rt;
    chp_pkg::sq_side_t cur_sd;
    logic [34:0]       trial;
    logic              take;

    if (s == 0) begin : g_first
      assign cur_vld = in_valid;
      assign cur_rem = radicand;
      assign cur_rt  = '0;
      assign cur_sd  = side_in;
    end else begin : g_next
      assign cur_vld = vld[s];
      assign cur_rem = rem[s];
      assign cur_rt  = rt[s];
      assign cur_sd  = sd[s];
    end

    // trial = 2*R*2^I + 2^(2I)
    assign trial = ({18'd0, cur_rt} << (I + 1)) + (35'd1 << (2 * I));
    assign take  = {1'b0, cur_rem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= take ? (cur_rem - trial[33:0]) : cur_rem;
      rt[s+1]  <= take ? (cur_rt | (17'd1 << I)) : cur_rt;
      sd[s+1]  <= cur_sd;
    end
  end

  assign out_valid = vld[17];
  assign root      = rt[17];
  assign side_out  = sd[17];

endmodule

// ----- rtl/chp_exp.sv -----
// Pipelined exp(-q) for q in Q.12 below 32, result in Q.12 (39 stages).
// Range reduction by log2(e), 12-term Horner series in Q.30. Depends on chp_pkg.
module chp_exp (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [16:0]        q,
  input  chp_pkg::ex_side_t  side_in,
  output logic               out_valid,
  output logic [12:0]        e,
  output chp_pkg::ex_side_t  side_out
);

  // Stage 0: u = q * log2(e)
  logic              v0;
  logic [35:0]       u;
  chp_pkg::ex_side_t sd0;
  logic [47:0]       u_full;

  assign u_full = {31'd0, q} * {17'd0, chp_pkg::L2E_Q30};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    u   <= u_full[47:12];
    sd0 <= side_in;
  end

  // Stage 1: split integer part, scale fraction by ln(2); seeds the series
  logic              hv   [0:12];
  logic [30:0]       hacc [0:12];
  logic [29:0]       hy   [0:12];
  logic [5:0]        hk   [0:12];
  chp_pkg::ex_side_t hsd  [0:12];
  logic [59:0]       y_full;

  assign y_full = {30'd0, u[29:0]} * {30'd0, chp_pkg::LN2_Q30};

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else begin
      hv[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    hacc[0] <= 31'h4000_0000;
    hy[0]   <= y_full[59:30];
    hk[0]   <= u[35:30];
    hsd[0]  <= sd0;
  end

  // Horner steps, n = 12 down to 1, three stages each
  logic              av   [0:11];
  logic [29:0]       aval [0:11];
  logic [29:0]       ay   [0:11];
  logic [5:0]        ak   [0:11];
  chp_pkg::ex_side_t asd  [0:11];
  logic              bv   [0:11];
  logic [29:0]       bq0  [0:11];
  logic [29:0]       bval [0:11];
  logic [29:0]       by   [0:11];
  logic [5:0]        bk   [0:11];
  chp_pkg::ex_side_t bsd  [0:11];

  for (genvar j = 0; j < 12; j++) begin : g_horner
    localparam int N = 12 - j;
    localparam logic [31:0] M = chp_pkg::RECIP[N];
    logic [60:0] p;
    logic [61:0] qq;
    logic [33:0] q0n;
    logic [33:0] rmd;
    logic        inc;
    logic [29:0] qn;

    assign p   = {31'd0, hy[j]} * {30'd0, hacc[j]};
    assign qq  = {32'd0, aval[j]} * {30'd0, M};
    assign q0n = {4'd0, bq0[j]} * 34'(N);
    assign rmd = {4'd0, bval[j]} - q0n;
    // reciprocal estimate is at most one low
    assign inc = rmd >= 34'(N);
    assign qn  = bq0[j] + {29'd0, inc};

    always_ff @(posedge clk) begin
      if (rst) begin
        av[j]   <= 1'b0;
        bv[j]   <= 1'b0;
        hv[j+1] <= 1'b0;
      end else begin
        av[j]   <= hv[j];
        bv[j]   <= av[j];
        hv[j+1] <= bv[j];
      end
    end

    always_ff @(posedge clk) begin
      aval[j]   <= p[59:30];
      ay[j]     <= hy[j];
      ak[j]     <= hk[j];
      asd[j]    <= hsd[j];
      bq0[j]    <= qq[61:32];
      bval[j]   <= aval[j];
      by[j]     <= ay[j];
      bk[j]     <= ak[j];
      bsd[j]    <= asd[j];
      hacc[j+1] <= 31'h4000_0000 - {1'b0, qn};
      hy[j+1]   <= by[j];
      hk[j+1]   <= bk[j];
      hsd[j+1]  <= bsd[j];
    end
  end

  // Final: scale by 2^-k and round half up to Q.12
  logic [6:0]  sh;
  logic [31:0] sum;
  logic [31:0] shifted;

  assign sh      = 7'd18 + {1'b0, hk[12]};
  assign sum     = {1'b0, hacc[12]} + (32'd1 << (sh - 7'd1));
  assign shifted = sum >> sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= hv[12];
    end
  end

  always_ff @(posedge clk) begin
    e        <= (sh >= 7'd32) ? 13'd0 : shifted[12:0];
    side_out <= hsd[12];
  end

endmodule

// ----- rtl/caldera_height_pixel.sv -----
// Top level of the caldera height pixel pipeline: configuration registers,
// radial distance, divisions and output scaling. Uses chp_pkg, chp_sqrt, chp_exp.
//
// Usage:
//   Pixels enter on start with coord_x, coord_y and noise_sample. busy is
//   always low, so one pixel is taken every cycle that start is high.
//   Each pixel yields one result: height, inside_rim and saturated appear
//   with done high for one cycle. Throughput is one pixel per clock; each
//   pixel passes through the 17-stage square root, the 17-stage quotient
//   array and the 39-stage exponential.
//   Configuration: cfg_valid with cfg_index and cfg_data writes a register
//   (cfg_ready is always high); indexes beyond the list are dropped.
//   Write registers only while no pixel is in flight.
//   Reset (rst, synchronous) loads register defaults and clears all stage
//   valid bits; in-flight pixels are dropped. The receiver cannot stall:
//   every result must be taken in the cycle done is high.
module caldera_height_pixel (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic [15:0]        noise_sample,
  output logic               done,
  output logic signed [15:0] height,
  output logic               inside_rim,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [14:0]        rim_radius;
  logic [14:0]        inner_width;
  logic [14:0]        outer_width;
  logic signed [15:0] bottom_height;
  logic [14:0]        radial_noise_gain;
  logic [14:0]        height_noise_gain;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x          <= 16'sd2048;
      center_y          <= 16'sd2048;
      rim_radius        <= 15'd1024;
      inner_width       <= 15'd205;
      outer_width       <= 15'd410;
      bottom_height     <= 16'sd819;
      radial_noise_gain <= 15'd0;
      height_noise_gain <= 15'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (chp_pkg::reg_idx_t'(cfg_index))
        chp_pkg::REG_CENTER_X:          center_x          <= cfg_data;
        chp_pkg::REG_CENTER_Y:          center_y          <= cfg_data;
        chp_pkg::REG_RIM_RADIUS:        rim_radius        <= cfg_data[14:0];
        chp_pkg::REG_INNER_WIDTH:       inner_width       <= cfg_data[14:0];
        chp_pkg::REG_OUTER_WIDTH:       outer_width       <= cfg_data[14:0];
        chp_pkg::REG_BOTTOM_HEIGHT:     bottom_height     <= cfg_data;
        chp_pkg::REG_RADIAL_NOISE_GAIN: radial_noise_gain <= cfg_data[14:0];
        chp_pkg::REG_HEIGHT_NOISE_GAIN: height_noise_gain <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Stage 1: offsets from centre, noise t = 2n - 1 in Q.16
  logic               v1;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [17:0] t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dx <= {coord_x[15], coord_x} - {center_x[15], center_x};
    dy <= {coord_y[15], coord_y} - {center_y[15], center_y};
    t1 <= $signed({1'b0, noise_sample, 1'b0}) - 18'sd65536;
  end

  // Stage 2: squares and noise products
  logic               v2;
  logic [31:0]        dx2;
  logic [31:0]        dy2;
  logic signed [33:0] rprod;
  logic signed [33:0] hprod;
  logic signed [33:0] dx2_full;
  logic signed [33:0] dy2_full;

  assign dx2_full = dx * dx;
  assign dy2_full = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dx2   <= dx2_full[31:0];
    dy2   <= dy2_full[31:0];
    rprod <= $signed({1'b0, radial_noise_gain}) * t1;
    hprod <= $signed({1'b0, height_noise_gain}) * t1;
  end

  // Stage 3: squared distance, noise terms
  logic              v3;
  logic [33:0]       d2;
  chp_pkg::sq_side_t sq_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d2       <= {2'd0, dx2} + {2'd0, dy2};
    sq_in.nr <= rprod[33:16];
    sq_in.m  <= chp_pkg::ONE_Q12 + hprod[33:16];
  end

  // Square root
  logic              sq_valid;
  logic [16:0]       root_dist;
  chp_pkg::sq_side_t sq_out;

  chp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .radicand  (d2),
    .side_in   (sq_in),
    .out_valid (sq_valid),
    .root      (root_dist),
    .side_out  (sq_out)
  );

  // Stage 4: shifted radius r
  logic               v4;
  logic signed [17:0] r4;
  logic signed [17:0] m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    r4 <= $signed({1'b0, root_dist}) - $signed({3'd0, rim_radius}) + sq_out.nr;
    m4 <= sq_out.m;
  end

  // Stage 5: r^2 and width squares
  logic               v5;
  logic [33:0]        r2;
  logic               inside5;
  logic [29:0]        si2;
  logic [29:0]        so2;
  logic signed [17:0] m5;
  logic signed [35:0] r2_full;

  assign r2_full = r4 * r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    r2      <= r2_full[33:0];
    inside5 <= r4[17];
    si2     <= inner_width * inner_width;
    so2     <= outer_width * outer_width;
    m5      <= m4;
  end

  // Stage 6: divider setup
  logic               v6;
  logic               inside6;
  logic               deep6;
  logic               zero6;
  logic [30:0]        den_i6;
  logic [34:0]        den_o6;
  logic [31:0]        pi6;
  logic [35:0]        po6;
  logic [3:0]         lo6;
  logic signed [17:0] m6;
  logic [34:0]        den_o_sum;

  assign den_o_sum = {5'd0, so2} + {1'b0, r2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    inside6 <= inside5;
    // bowl term vanishes once r^2 reaches 64 si^2
    deep6   <= inside5 && ({2'd0, r2} < {si2, 6'd0});
    zero6   <= den_o_sum == 35'd0;
    den_i6  <= {si2, 1'b0};
    den_o6  <= den_o_sum;
    pi6     <= {2'd0, r2[33:4]};
    po6     <= {6'd0, so2};
    lo6     <= r2[3:0];
    m6      <= m5;
  end

  // Quotient array: inner q = r^2*2^12/(2 si^2), 17 bits;
  // outer so^2*2^12/(so^2 + r^2), 13 bits
  logic               dv   [1:17];
  logic [31:0]        dpi  [1:17];
  logic [35:0]        dpo  [1:17];
  logic [16:0]        dqi  [1:17];
  logic [12:0]        dqo  [1:17];
  logic [30:0]        ddi  [1:17];
  logic [34:0]        ddo  [1:17];
  logic [3:0]         dlo  [1:17];
  logic               dins [1:17];
  logic               ddp  [1:17];
  logic               dzr  [1:17];
  logic signed [17:0] dm   [1:17];

  for (genvar s = 0; s < 17; s++) begin : g_div
    localparam int I = 16 - s;
    logic               c_v;
    logic [31:0]        c_pi;
    logic [35:0]        c_po;
    logic [16:0]        c_qi;
    logic [12:0]        c_qo;
    logic [30:0]        c_di;
    logic [34:0]        c_do;
    logic [3:0]         c_lo;
    logic               c_ins;
    logic               c_dp;
    logic               c_zr;
    logic signed [17:0] c_m;
    logic [31:0]        cand_i;
    logic               ge_i;
    logic [35:0]        n_po;
    logic [12:0]        n_qo;

    if (s == 0) begin : g_first
      assign c_v   = v6;
      assign c_pi  = pi6;
      assign c_po  = po6;
      assign c_qi  = '0;
      assign c_qo  = '0;
      assign c_di  = den_i6;
      assign c_do  = den_o6;
      assign c_lo  = lo6;
      assign c_ins = inside6;
      assign c_dp  = deep6;
      assign c_zr  = zero6;
      assign c_m   = m6;
    end else begin : g_next
      assign c_v   = dv[s];
      assign c_pi  = dpi[s];
      assign c_po  = dpo[s];
      assign c_qi  = dqi[s];
      assign c_qo  = dqo[s];
      assign c_di  = ddi[s];
      assign c_do  = ddo[s];
      assign c_lo  = dlo[s];
      assign c_ins = dins[s];
      assign c_dp  = ddp[s];
      assign c_zr  = dzr[s];
      assign c_m   = dm[s];
    end

    if (I == 16) begin : g_ifirst
      assign cand_i = c_pi;
    end else begin : g_ishift
      logic [15:0] nbits;
      assign nbits  = {c_lo, 12'd0};
      assign cand_i = {c_pi[30:0], nbits[I]};
    end
    assign ge_i = cand_i >= {1'b0, c_di};

    if (I > 12) begin : g_oidle
      assign n_po = c_po;
      assign n_qo = c_qo;
    end else begin : g_oact
      logic [35:0] cand_o;
      logic        ge_o;
      if (I == 12) begin : g_ofirst
        assign cand_o = c_po;
      end else begin : g_oshift
        assign cand_o = {c_po[34:0], 1'b0};
      end
      assign ge_o = cand_o >= {1'b0, c_do};
      assign n_po = ge_o ? (cand_o - {1'b0, c_do}) : cand_o;
      assign n_qo = c_qo | (ge_o ? (13'd1 << I) : 13'd0);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else begin
        dv[s+1] <= c_v;
      end
    end

    always_ff @(posedge clk) begin
      dpi[s+1]  <= ge_i ? (cand_i - {1'b0, c_di}) : cand_i;
      dqi[s+1]  <= c_qi | (ge_i ? (17'd1 << I) : 17'd0);
      dpo[s+1]  <= n_po;
      dqo[s+1]  <= n_qo;
      ddi[s+1]  <= c_di;
      ddo[s+1]  <= c_do;
      dlo[s+1]  <= c_lo;
      dins[s+1] <= c_ins;
      ddp[s+1]  <= c_dp;
      dzr[s+1]  <= c_zr;
      dm[s+1]   <= c_m;
    end
  end

  // Exponential of the bowl term
  chp_pkg::ex_side_t ex_in;
  chp_pkg::ex_side_t ex_out;
  logic              ex_valid;
  logic [12:0]       e_raw;

  assign ex_in.in_bowl = dins[17];
  assign ex_in.deep    = ddp[17];
  assign ex_in.zo      = dzr[17] ? 13'd4096 : dqo[17];
  assign ex_in.m       = dm[17];

  chp_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[17]),
    .q         (dqi[17]),
    .side_in   (ex_in),
    .out_valid (ex_valid),
    .e         (e_raw),
    .side_out  (ex_out)
  );

  // Stage 7: e * (1 - b)
  logic               v7;
  logic signed [31:0] bprod;
  logic               inside7;
  logic [12:0]        zo7;
  logic signed [17:0] m7;
  logic [12:0]        e_eff;
  logic signed [17:0] b_ext;
  logic signed [17:0] one_minus_b;

  assign e_eff       = ex_out.deep ? e_raw : 13'd0;
  assign b_ext       = {{2{bottom_height[15]}}, bottom_height};
  assign one_minus_b = chp_pkg::ONE_Q12 - b_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    bprod   <= $signed({1'b0, e_eff}) * one_minus_b;
    inside7 <= ex_out.in_bowl;
    zo7     <= ex_out.zo;
    m7      <= ex_out.m;
  end

  // Stage 8: select bowl or falloff
  logic               v8;
  logic signed [17:0] z8;
  logic               inside8;
  logic signed [17:0] m8;
  logic signed [19:0] zi;

  assign zi = {{4{bottom_height[15]}}, bottom_height} + bprod[31:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    z8      <= inside7 ? zi[17:0] : $signed({5'd0, zo7});
    inside8 <= inside7;
    m8      <= m7;
  end

  // Stage 9: height noise scaling
  logic               v9;
  logic signed [35:0] hm9;
  logic               inside9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    hm9     <= z8 * m8;
    inside9 <= inside8;
  end

  // Stage 10: saturate and drive result
  logic signed [23:0] h_full;
  logic               h_hi;
  logic               h_lo;

  assign h_full = hm9[35:12];
  assign h_hi   = h_full > 24'sd32767;
  assign h_lo   = h_full < -24'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
  end

  always_ff @(posedge clk) begin
    height     <= h_hi ? 16'sh7fff : (h_lo ? 16'sh8000 : h_full[15:0]);
    inside_rim <= inside9;
    saturated  <= h_hi || h_lo;
  end

  // Checks
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (height == 16'sh7fff || height == 16'sh8000))
    else $error("saturated flag without limit value");

  a_falloff_bound: assert property (@(posedge clk) disable iff (rst)
    (v8 && !inside8) |-> (z8 >= 18'sd0 && z8 <= chp_pkg::ONE_Q12))
    else $error("falloff height out of range");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for caldera_height_pixel: drives pixels and register
// writes, predicts each height in a scoreboard class. Depends on rtl/chp_pkg.sv.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_REGS    = 8;
  localparam int DRAIN       = 100;     // beyond the pipeline depth
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] height;
    logic               in_bowl;
    logic               sat;
  } height_t;

  class height_scoreboard;
    logic [15:0] regv [NUM_REGS];
    height_t     pending [$];
    int          errors;

    function void reset_regs();
      regv = '{16'd2048, 16'd2048, 16'd1024, 16'd205, 16'd410, 16'd819, 16'd0, 16'd0};
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
      if (idx < NUM_REGS) begin
        if (idx == chp_pkg::REG_CENTER_X || idx == chp_pkg::REG_CENTER_Y ||
            idx == chp_pkg::REG_BOTTOM_HEIGHT)
          regv[idx] = data;
        else
          regv[idx] = {1'b0, data[14:0]};
      end
    endfunction

    function longint clamp30(longint v);
      longint lim;
      lim = longint'(1) << 30;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint int_sqrt(longint v);
      longint res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // exp(-q), q in Q.12, via 2^-k * exp(-y) with a truncating Horner series
    function longint exp_neg(longint q);
      longint u, k, yv, acc, sh, one30;
      one30 = longint'(1) << 30;
      u = (q * longint'(chp_pkg::L2E_Q30)) >> 12;
      k = u >> 30;
      yv = ((u & (one30 - 1)) * longint'(chp_pkg::LN2_Q30)) >> 30;
      acc = one30;
      for (int n = 12; n >= 1; n--)
        acc = one30 - ((yv * acc) >> 30) / n;
      sh = 18 + k;
      if (sh >= 62) return 0;
      return (acc + (longint'(1) << (sh - 1))) >> sh;
    endfunction

    function void note_pixel(logic signed [15:0] px, logic signed [15:0] py,
                             logic [15:0] noise);
      longint t, cx, cy, radius, si, so, b, rg, hg, dx, dy, d2, r, r2;
      longint e, z, m, h, den, whole, rem, q, so2;
      height_t res;
      t = 2 * longint'(noise) - 65536;
      cx = longint'($signed(regv[chp_pkg::REG_CENTER_X]));
      cy = longint'($signed(regv[chp_pkg::REG_CENTER_Y]));
      radius = regv[chp_pkg::REG_RIM_RADIUS];
      si = regv[chp_pkg::REG_INNER_WIDTH];
      so = regv[chp_pkg::REG_OUTER_WIDTH];
      b = longint'($signed(regv[chp_pkg::REG_BOTTOM_HEIGHT]));
      rg = regv[chp_pkg::REG_RADIAL_NOISE_GAIN];
      hg = regv[chp_pkg::REG_HEIGHT_NOISE_GAIN];
      dx = clamp30(longint'(px) - cx);
      dy = clamp30(longint'(py) - cy);
      d2 = dx * dx + dy * dy;
      r = clamp30(int_sqrt(d2) - radius + ((rg * t) >>> 16));
      r2 = r * r;
      res.in_bowl = r < 0;
      if (res.in_bowl) begin
        e = 0;
        den = 2 * si * si;
        if (den != 0 && r2 / 64 < si * si) begin
          whole = r2 / den;
          rem = r2 % den;
          q = (whole << 12) + (rem << 12) / den;
          if (q < (longint'(32) << 12)) e = exp_neg(q);
        end
        z = b + ((e * (4096 - b)) >>> 12);
      end else begin
        so2 = so * so;
        den = so2 + r2;
        z = (den == 0) ? 4096 : (so2 << 12) / den;
      end
      m = 4096 + ((hg * t) >>> 16);
      h = (z * m) >>> 12;
      res.sat = 1'b0;
      if (h > 32767) begin
        h = 32767;
        res.sat = 1'b1;
      end
      if (h < -32768) begin
        h = -32768;
        res.sat = 1'b1;
      end
      res.height = h[15:0];
      pending.push_back(res);
    endfunction

    task report(string msg);
      $display("tb mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [15:0] h, logic ins, logic sat);
      height_t exp_res;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result height=%0d", h));
        return;
      end
      exp_res = pending.pop_front();
      if (h !== exp_res.height)
        report($sformatf("height %0d, expected %0d", h, exp_res.height));
      if (ins !== exp_res.in_bowl)
        report($sformatf("inside_rim %0b, expected %0b", ins, exp_res.in_bowl));
      if (sat !== exp_res.sat)
        report($sformatf("saturated %0b, expected %0b", sat, exp_res.sat));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] coord_x = '0;
  logic signed [15:0] coord_y = '0;
  logic [15:0]        noise_sample = '0;
  logic               done;
  logic signed [15:0] height;
  logic               inside_rim;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  height_scoreboard sb;
  int               idle_pct;
  int               cycles;

  caldera_height_pixel DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Track accepted transactions on every port
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_pixel(coord_x, coord_y, noise_sample);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (done) sb.check_result(height, inside_rim, saturated);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task write_reg(logic [3:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task send_pixel(logic signed [15:0] px, logic signed [15:0] py, logic [15:0] noise);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    start = 1'b1;
    coord_x = px;
    coord_y = py;
    noise_sample = noise;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Lower start and let the pipeline empty before touching registers
  task drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task set_all(logic [15:0] v [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_reg(chp_pkg::reg_idx_t'(i), v[i]);
  endtask

  task random_config();
    logic [15:0] v [NUM_REGS];
    v[chp_pkg::REG_CENTER_X] =
      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16383));
    v[chp_pkg::REG_CENTER_Y] =
      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16383));
    v[chp_pkg::REG_RIM_RADIUS] =
      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8191));
    v[chp_pkg::REG_INNER_WIDTH] =
      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
    v[chp_pkg::REG_OUTER_WIDTH] =
      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
    v[chp_pkg::REG_BOTTOM_HEIGHT] = 16'($urandom);
    v[chp_pkg::REG_RADIAL_NOISE_GAIN] =
      ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
    v[chp_pkg::REG_HEIGHT_NOISE_GAIN] =
      ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
    set_all(v);
  endtask

  // Mostly pixels around the rim, some anywhere in the plane
  task random_pixels(int count);
    logic signed [15:0] cx, cy;
    int span;
    for (int i = 0; i < count; i++) begin
      cx = sb.regv[chp_pkg::REG_CENTER_X];
      cy = sb.regv[chp_pkg::REG_CENTER_Y];
      span = sb.regv[chp_pkg::REG_RIM_RADIUS] * 2 + 512;
      if ($urandom_range(3) == 0)
        send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_pixel(16'(cx + $signed($urandom_range(2 * span) - span)),
                   16'(cy + $signed($urandom_range(2 * span) - span)), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] v [NUM_REGS];
    int pcts [4] = '{0, 46, 29, 0};
    sb = new();
    sb.reset_regs();
    idle_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Defaults: centre, rim, far corners, noise extremes
    send_pixel(16'sd2048, 16'sd2048, 16'd0);
    send_pixel(16'sd2048, 16'sd2048, 16'hFFFF);
    send_pixel(16'sd3072, 16'sd2048, 16'h8000);
    send_pixel(16'sh7FFF, 16'sh7FFF, 16'd0);
    send_pixel(-16'sd32768, -16'sd32768, 16'hFFFF);
    send_pixel(16'sh7FFF, -16'sd32768, 16'h5555);
    send_pixel(-16'sd32768, 16'sh7FFF, 16'hAAAA);
    drain();

    // Deep bowl with full noise; writes beyond the list must be dropped
    v = '{16'd0, 16'd0, 16'h7FFF, 16'd1, 16'd1, 16'h8000, 16'h7FFF, 16'h7FFF};
    set_all(v);
    for (int i = NUM_REGS; i < 16; i++) write_reg(4'(i), 16'($urandom));
    send_pixel(16'sd0, 16'sd0, 16'd0);
    send_pixel(16'sd0, 16'sd0, 16'hFFFF);
    send_pixel(16'sd4096, 16'sd0, 16'h8000);
    send_pixel(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    drain();

    // Zero widths and large floor: bowl term gone, falloff steps at r == 0
    v = '{16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'h7FFF};
    set_all(v);
    send_pixel(16'sd0, 16'sd0, 16'hFFFF);
    send_pixel(16'sd100, 16'sd0, 16'h8000);
    send_pixel(16'sd101, 16'sd0, 16'hFFFF);
    send_pixel(16'sd60, 16'sd80, 16'd0);
    drain();

    // Wide bowl, shallow falloff
    v = '{16'h7FFF, 16'h8000, 16'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 16'd0};
    set_all(v);
    send_pixel(16'sh7FFF, -16'sd32768, 16'd0);
    send_pixel(16'sd0, 16'sd0, 16'hFFFF);
    send_pixel(-16'sd32768, 16'sh7FFF, 16'h1234);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = pcts[ph % 4];
      random_config();
      random_pixels(45);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/chp_pkg.sv
rtl/chp_sqrt.sv
rtl/chp_exp.sv
rtl/caldera_height_pixel.sv
dv/tb.sv
